// File: hdl/sft_pkg.sv
`default_nettype none

package sft_pkg;

  localparam int TS_W       = 64;
  localparam int FREQ_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int FFR_W      = 10;
  localparam int RATE_W     = 32;
  localparam int HALF_W     = 32;
  localparam int MUL_W      = HALF_W + GAIN_W;
  localparam int DIV_N_W    = FREQ_W + 16;
  localparam int DIV_D_W    = TS_W;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam int AVG_DEPTH_DEF = 8;

  localparam logic [FREQ_W-1:0] FREQ_RST = FREQ_W'(1000000);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(256);
  localparam logic [FFR_W-1:0]  FFR_RST  = FFR_W'(60);

  localparam logic [REG_IDX_W-1:0] REG_TICK_FREQ  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_RATE_GAIN  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_FIXED_EN   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_FIXED_RATE = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_AVG_EN     = REG_IDX_W'(4);

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_PAUSE  = 2'd1,
    OP_RESUME = 2'd2,
    OP_RESET  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL_LO,
    S_MUL_HI,
    S_SCALE,
    S_DIV_RATE,
    S_DIV_FIX,
    S_COMMIT,
    S_RING,
    S_DIV_AVG,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [FREQ_W-1:0] tick_frequency;
    logic [GAIN_W-1:0] rate_gain;
    logic              fixed_step_enable;
    logic [FFR_W-1:0]  fixed_frame_rate;
    logic              averaging_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic mul_lo;
    logic mul_hi;
    logic scale;
    logic rate_cap;
    logic fix_start;
    logic fix_cap;
    logic commit;
    logic ring_upd;
    logic avg_cap;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic compute;
    logic fixed;
    logic avg;
    logic div_done;
    logic avg_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/sft_regs.sv
`default_nettype none

module sft_regs import sft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_frequency    <= FREQ_RST;
      cfg.rate_gain         <= GAIN_RST;
      cfg.fixed_step_enable <= 1'b0;
      cfg.fixed_frame_rate  <= FFR_RST;
      cfg.averaging_enable  <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_TICK_FREQ:  cfg.tick_frequency    <= pwdata[FREQ_W-1:0];
        REG_RATE_GAIN:  cfg.rate_gain         <= pwdata[GAIN_W-1:0];
        REG_FIXED_EN:   cfg.fixed_step_enable <= pwdata[0];
        REG_FIXED_RATE: cfg.fixed_frame_rate  <= pwdata[FFR_W-1:0];
        REG_AVG_EN:     cfg.averaging_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TICK_FREQ:  prdata = APB_DATA_W'(cfg.tick_frequency);
      REG_RATE_GAIN:  prdata = APB_DATA_W'(cfg.rate_gain);
      REG_FIXED_EN:   prdata = APB_DATA_W'(cfg.fixed_step_enable);
      REG_FIXED_RATE: prdata = APB_DATA_W'(cfg.fixed_frame_rate);
      REG_AVG_EN:     prdata = APB_DATA_W'(cfg.averaging_enable);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/sft_div.sv
`default_nettype none

module sft_div import sft_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_N_W);
  localparam int CMP_W = DIV_D_W + 1;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_N_W-1:0] rem;
  logic [DIV_N_W-1:0] quot;
  logic [DIV_D_W-1:0] dvs;
  logic [DIV_N_W:0]   trial;
  logic [CMP_W-1:0]   diff;
  logic               ge;

  assign trial    = {rem, quot[DIV_N_W-1]};
  assign ge       = CMP_W'(trial) >= CMP_W'(dvs);
  assign diff     = CMP_W'(trial) - CMP_W'(dvs);
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[DIV_N_W-1:0] : trial[DIV_N_W-1:0];
      quot <= {quot[DIV_N_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: hdl/sft_dp.sv
`default_nettype none

module sft_dp import sft_pkg::*; #(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  cmd_t            cmd,
  output sts_t            sts,
  input  logic [1:0]      operation,
  input  logic [TS_W-1:0] timestamp,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [TS_W-1:0] delta_ticks,
  output logic [TS_W-1:0] elapsed_ticks,
  output logic [RATE_W-1:0] frame_rate,
  output logic            paused
);

  localparam int SLOT_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int AVG_L   = $clog2(AVG_DEPTH);
  localparam int SUM_W   = RATE_W + AVG_L;
  localparam int RCP_W   = 48;
  localparam int CHUNK_W = 16;
  localparam int RCP_SH  = SUM_W + AVG_L;
  localparam int PART_W  = SUM_W + CHUNK_W;
  localparam int ACC_W   = SUM_W + RCP_W;
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << RCP_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

  op_t               op_r;
  logic [TS_W-1:0]   ts_r;
  logic [TS_W-1:0]   elapsed_acc;
  logic [TS_W-1:0]   last_stamp;
  logic              stamp_valid;
  logic              pause_flag;
  logic [TS_W-1:0]   iv;
  logic [MUL_W-1:0]  lo_prod;
  logic [MUL_W-1:0]  hi_prod;
  logic [TS_W-1:0]   delta_r;
  logic [RATE_W-1:0] rate_r;
  logic [RATE_W-1:0] fps_r;

  logic [HALF_W-1:0] mul_a;
  logic [MUL_W-1:0]  mul_p;
  logic [TS_W:0]     sc_sum;
  logic [TS_W-1:0]   scaled;

  logic               div_start;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;
  logic [RATE_W-1:0]  rate_sat;
  logic [FFR_W-1:0]   ffr_eff;

  logic [RATE_W-1:0]    ring [AVG_DEPTH];
  logic [AVG_DEPTH-1:0] ring_vld;
  logic [RATE_W-1:0]    rd_data;
  logic                 rd_vld;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    slot_inc;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_next;
  logic [RATE_W-1:0]    old_rate;

  logic [SUM_W-1:0]   avg_x;
  logic [ACC_W-1:0]   avg_acc;
  logic [1:0]         avg_cnt;
  logic [CHUNK_W-1:0] rcp_chunk;
  logic [PART_W-1:0]  avg_part;

  assign sts.compute  = (op_r == OP_UPDATE) && !pause_flag && stamp_valid;
  assign sts.fixed    = cfg.fixed_step_enable;
  assign sts.avg      = cfg.averaging_enable;
  assign sts.div_done = div_done;
  assign sts.avg_done = (avg_cnt == 2'd0);
  assign sts.out_free = !out_valid || !out_stall;

  assign mul_a  = cmd.mul_hi ? iv[TS_W-1:HALF_W] : iv[HALF_W-1:0];
  assign mul_p  = MUL_W'(mul_a) * MUL_W'(cfg.rate_gain);
  assign sc_sum = {1'b0, hi_prod[39:0], 24'b0} + {25'b0, lo_prod[MUL_W-1:8]};
  assign scaled = ((|hi_prod[MUL_W-1:40]) || sc_sum[TS_W]) ? '1 : sc_sum[TS_W-1:0];

  assign ffr_eff  = (cfg.fixed_frame_rate == '0) ? FFR_W'(1) : cfg.fixed_frame_rate;
  assign rate_sat = ((iv == '0) || (|div_q[DIV_N_W-1:RATE_W])) ? '1 : div_q[RATE_W-1:0];

  assign slot_inc = (slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot + 1'b1;
  assign old_rate = rd_vld ? rd_data : '0;
  assign sum_next = sum - SUM_W'(old_rate) + SUM_W'(rate_r);

  // The average is the sum times a rounded-up reciprocal of the depth, taken in
  // three 16-bit slices of the constant. The scaling is exact for every sum.
  always_comb begin
    case (avg_cnt)
      2'd3:    rcp_chunk = RCP[47:32];
      2'd2:    rcp_chunk = RCP[31:16];
      default: rcp_chunk = RCP[15:0];
    endcase
  end

  assign avg_part = PART_W'(avg_x) * PART_W'(rcp_chunk);

  assign div_start = cmd.scale | cmd.fix_start;

  always_comb begin
    if (cmd.fix_start) begin
      div_n = DIV_N_W'(cfg.tick_frequency);
      div_d = DIV_D_W'(ffr_eff);
    end else begin
      div_n = {cfg.tick_frequency, 16'b0};
      div_d = iv;
    end
  end

  sft_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(operation);
      ts_r <= timestamp;
    end
    if (cmd.decide) begin
      iv <= ts_r - last_stamp;
      if (!sts.compute) begin
        delta_r <= '0;
        fps_r   <= '0;
      end
    end
    if (cmd.mul_lo) begin
      lo_prod <= mul_p;
    end
    if (cmd.mul_hi) begin
      hi_prod <= mul_p;
    end
    if (cmd.scale) begin
      delta_r <= scaled;
    end
    if (cmd.rate_cap) begin
      rate_r <= rate_sat;
    end
    if (cmd.fix_cap) begin
      delta_r <= TS_W'(div_q);
    end
    if (cmd.commit) begin
      fps_r   <= rate_r;
      rd_data <= ring[slot_inc];
      rd_vld  <= ring_vld[slot_inc];
    end
    if (cmd.ring_upd) begin
      ring[slot_inc] <= rate_r;
      avg_x          <= sum_next;
      avg_acc        <= '0;
    end else if (avg_cnt != 2'd0) begin
      avg_acc <= {avg_acc[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(avg_part);
    end
    if (cmd.avg_cap) begin
      fps_r <= avg_acc[RCP_SH +: RATE_W];
    end
    if (cmd.finish) begin
      delta_ticks   <= delta_r;
      elapsed_ticks <= elapsed_acc;
      frame_rate    <= fps_r;
      paused        <= pause_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_acc <= '0;
      last_stamp  <= '0;
      stamp_valid <= 1'b0;
      pause_flag  <= 1'b0;
      ring_vld    <= '0;
      slot        <= '0;
      sum         <= '0;
      avg_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.decide && !sts.compute) begin
        case (op_r)
          OP_UPDATE: begin
            if (!pause_flag) begin
              last_stamp  <= ts_r;
              stamp_valid <= 1'b1;
            end
          end
          OP_PAUSE: pause_flag <= 1'b1;
          OP_RESUME: begin
            pause_flag  <= 1'b0;
            last_stamp  <= ts_r;
            stamp_valid <= 1'b1;
          end
          OP_RESET: begin
            elapsed_acc <= '0;
            last_stamp  <= ts_r;
            stamp_valid <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.commit) begin
        elapsed_acc <= elapsed_acc + delta_r;
        last_stamp  <= ts_r;
      end
      if (cmd.ring_upd) begin
        ring_vld[slot_inc] <= 1'b1;
        slot               <= slot_inc;
        sum                <= sum_next;
        avg_cnt            <= 2'd3;
      end else if (avg_cnt != 2'd0) begin
        avg_cnt <= avg_cnt - 2'd1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/sft_ctrl.sv
`default_nettype none

module sft_ctrl import sft_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.compute ? S_MUL_LO : S_FINISH;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_DIV_RATE;
      end
      S_DIV_RATE: begin
        if (sts.div_done) begin
          cmd.rate_cap = 1'b1;
          if (sts.fixed) begin
            cmd.fix_start = 1'b1;
            state_next    = S_DIV_FIX;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end
      S_DIV_FIX: begin
        if (sts.div_done) begin
          cmd.fix_cap = 1'b1;
          state_next  = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = sts.avg ? S_RING : S_FINISH;
      end
      S_RING: begin
        cmd.ring_upd = 1'b1;
        state_next   = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        if (sts.avg_done) begin
          cmd.avg_cap = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/scaled_frame_timer.sv
// Scaled frame timer. Each input transaction carries an operation (update,
// pause, resume, reset accumulator) and a free-running tick timestamp; each
// one produces exactly one output transaction with the scaled delta, the
// accumulated game time, a Q16.16 frame rate and the pause flag.
// Both channels use valid and stall; a transaction completes on a clock edge
// with valid high and stall low. Registers are written over the APB port.
// Pause, resume, reset, an update while paused and the first update after
// reset skip the arithmetic and go from the decide state straight to the
// finish state. A measured update runs the frame-rate division, a second
// division in fixed-step mode and the averaging multiply when averaging is
// on. The divider is radix-2 and is shared by the frame rate and the fixed
// step; the average is a reciprocal multiply taken in 16-bit slices.
// One item is in work at a time; in_stall is low only while the controller
// is idle. A finished result sits in the output register, so the next item
// can be accepted while the receiver stalls; that item then waits for the
// output register to free up before it completes.
// Synchronous reset clears the timer state, the history ring and the
// registers to their defaults, and drops out_valid.
`default_nettype none

module scaled_frame_timer import sft_pkg::*; #(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [TS_W-1:0]       timestamp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TS_W-1:0]       delta_ticks,
  output logic [TS_W-1:0]       elapsed_ticks,
  output logic [RATE_W-1:0]     frame_rate,
  output logic                  paused
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  sft_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sft_dp #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (operation),
    .timestamp     (timestamp),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .delta_ticks   (delta_ticks),
    .elapsed_ticks (elapsed_ticks),
    .frame_rate    (frame_rate),
    .paused        (paused)
  );

endmodule

`default_nettype wire

// File: hdl/sft_checker.sv
`default_nettype none

module sft_checker import sft_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [TS_W-1:0]   delta_ticks,
  input logic [RATE_W-1:0] frame_rate,
  input logic              paused
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_paused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && paused |-> delta_ticks == '0 && frame_rate == '0)
    else $error("paused result with nonzero delta or rate");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second input transaction taken while busy");

  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("new result appeared while controller busy");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(delta_ticks) && $stable(frame_rate))
    else $error("stalled output transaction changed");

endmodule

bind scaled_frame_timer sft_checker u_sft_checker (.*);

`default_nettype wire

// File: sim/tb_scaled_frame_timer.sv
class frame_timer_scoreboard;
  typedef struct {
    logic [63:0] delta;
    logic [63:0] elapsed;
    logic [31:0] rate;
    logic        paused;
  } timer_result_t;

  logic [31:0] tick_freq;
  logic [15:0] gain;
  logic        fixed_mode;
  logic [9:0]  fixed_fps;
  logic        avg_mode;

  logic [63:0] game_time;
  logic [63:0] last_stamp;
  logic        stamp_seen;
  logic        pause_flag;
  logic [31:0] rate_ring [sft_pkg::AVG_DEPTH_DEF];
  int          ring_slot;
  logic [34:0] ring_sum;

  timer_result_t expected_q[$];
  int            mismatches;

  function new();
    tick_freq  = sft_pkg::FREQ_RST;
    gain       = sft_pkg::GAIN_RST;
    fixed_mode = 1'b0;
    fixed_fps  = sft_pkg::FFR_RST;
    avg_mode   = 1'b1;
    game_time  = '0;
    last_stamp = '0;
    stamp_seen = 1'b0;
    pause_flag = 1'b0;
    foreach (rate_ring[i]) rate_ring[i] = '0;
    ring_slot  = 0;
    ring_sum   = '0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [sft_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    case (idx)
      sft_pkg::REG_TICK_FREQ:  tick_freq  = value;
      sft_pkg::REG_RATE_GAIN:  gain       = value[15:0];
      sft_pkg::REG_FIXED_EN:   fixed_mode = value[0];
      sft_pkg::REG_FIXED_RATE: fixed_fps  = value[9:0];
      sft_pkg::REG_AVG_EN:     avg_mode   = value[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Advances the timer state for one accepted input transaction and queues the
  // result that it must produce.
  function void note_input(sft_pkg::op_t op, logic [63:0] ts);
    timer_result_t res;
    logic [63:0]   iv;
    logic [79:0]   prod;
    logic [63:0]   quo;
    logic [31:0]   inst;
    logic [9:0]    divisor;
    res.delta = '0;
    res.rate  = '0;
    case (op)
      sft_pkg::OP_UPDATE: begin
        if (!pause_flag) begin
          if (!stamp_seen) begin
            last_stamp = ts;
            stamp_seen = 1'b1;
          end else begin
            iv = ts - last_stamp;
            last_stamp = ts;
            if (fixed_mode) begin
              divisor = (fixed_fps == 10'd0) ? 10'd1 : fixed_fps;
              res.delta = 64'(tick_freq / divisor);
            end else begin
              prod = iv * gain;
              res.delta = (prod[79:72] != 8'd0) ? '1 : prod[71:8];
            end
            game_time = game_time + res.delta;
            if (iv == 64'd0) begin
              inst = '1;
            end else begin
              quo = {tick_freq, 16'h0000} / iv;
              inst = (quo[63:32] != 32'd0) ? '1 : quo[31:0];
            end
            if (avg_mode) begin
              ring_slot = (ring_slot + 1) % sft_pkg::AVG_DEPTH_DEF;
              ring_sum = ring_sum - rate_ring[ring_slot] + inst;
              rate_ring[ring_slot] = inst;
              res.rate = 32'(ring_sum / 35'(sft_pkg::AVG_DEPTH_DEF));
            end else begin
              res.rate = inst;
            end
          end
        end
      end
      sft_pkg::OP_PAUSE: begin
        pause_flag = 1'b1;
      end
      sft_pkg::OP_RESUME: begin
        pause_flag = 1'b0;
        last_stamp = ts;
        stamp_seen = 1'b1;
      end
      default: begin
        game_time  = '0;
        last_stamp = ts;
        stamp_seen = 1'b1;
      end
    endcase
    res.elapsed = game_time;
    res.paused  = pause_flag;
    expected_q.push_back(res);
  endfunction

  function void check_result(logic [63:0] delta, logic [63:0] elapsed, logic [31:0] rate,
                             logic paused_now);
    timer_result_t exp_r;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: delta %h elapsed %h rate %h paused %b",
                 delta, elapsed, rate, paused_now);
    end else begin
      exp_r = expected_q.pop_front();
      if (exp_r.delta !== delta || exp_r.elapsed !== elapsed || exp_r.rate !== rate ||
          exp_r.paused !== paused_now) begin
        mismatches++;
        if (mismatches <= 10)
          $display("wrong result (exp/act): delta %h/%h elapsed %h/%h rate %h/%h paused %b/%b",
                   exp_r.delta, delta, exp_r.elapsed, elapsed, exp_r.rate, rate,
                   exp_r.paused, paused_now);
      end
    end
  endfunction
endclass

module tb_scaled_frame_timer;
  import sft_pkg::*;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int TAIL_CYCLES     = 200;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            operation = '0;
  logic [TS_W-1:0]       timestamp = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TS_W-1:0]       delta_ticks;
  logic [TS_W-1:0]       elapsed_ticks;
  logic [RATE_W-1:0]     frame_rate;
  logic                  paused;

  frame_timer_scoreboard sb;
  logic [63:0] stamp_now = '0;
  logic [31:0] cur_freq = FREQ_RST;
  int          quiet_cycles = 0;
  logic [31:0] stall_cycle = '0;
  int          stall_mode = 0;
  int          burst_left;

  scaled_frame_timer i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .timestamp     (timestamp),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .delta_ticks   (delta_ticks),
    .elapsed_ticks (elapsed_ticks),
    .frame_rate    (frame_rate),
    .paused        (paused)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic send_item(op_t op, logic [63:0] ts);
    in_valid  <= 1'b1;
    operation <= op;
    timestamp <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, ts);
  endtask

  task automatic pause_sender(int cycles, bit drain);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
    if (drain)
      while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic configure_phase(int ph);
    logic [31:0] f, g, fx, fr, av;
    case (ph)
      0:       begin f = 32'd1000000;  g = 32'd256;   fx = 0; fr = 32'd60;   av = 1; end
      1:       begin f = 32'hFFFFFFFF; g = 32'hFFFF;  fx = 0; fr = 32'd1000; av = 0; end
      2:       begin f = 32'd1;        g = 32'd0;     fx = 1; fr = 32'd1;    av = 1; end
      3:       begin f = 32'd48000000; g = 32'd512;   fx = 1; fr = 32'd1000; av = 1; end
      4:       begin f = 32'd0;        g = 32'd128;   fx = 1; fr = 32'd0;    av = 0; end
      5:       begin f = 32'd0;        g = 32'd256;   fx = 0; fr = 32'd60;   av = 1; end
      6:       begin f = 32'd27000000; g = 32'd300;   fx = 0; fr = 32'd144;  av = 1; end
      7:       begin f = 32'hFFFFFFFF; g = 32'd1;     fx = 1; fr = 32'd1023; av = 1; end
      default: begin
        f = $urandom; g = $urandom; fx = $urandom; fr = $urandom; av = $urandom;
      end
    endcase
    write_reg(REG_TICK_FREQ, f);
    write_reg(REG_RATE_GAIN, g);
    write_reg(REG_FIXED_EN, fx);
    write_reg(REG_FIXED_RATE, fr);
    write_reg(REG_AVG_EN, av);
    cur_freq = f;
  endtask

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return OP_UPDATE;
    else if (r < 80) return OP_PAUSE;
    else if (r < 92) return OP_RESUME;
    else return OP_RESET;
  endfunction

  // Mostly frame-sized intervals, with zero, short, wide and wrapping jumps mixed in.
  function automatic logic [63:0] next_stamp();
    int          pick;
    logic [63:0] step;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      step = 64'(cur_freq / $urandom_range(24, 240)) + 64'($urandom_range(0, 63));
    else if (pick < 68)
      step = 64'($urandom_range(1, 2000));
    else if (pick < 74)
      step = '0;
    else if (pick < 84)
      step = 64'($urandom);
    else if (pick < 92)
      step = {$urandom, $urandom};
    else begin
      stamp_now = {$urandom, $urandom};
      return stamp_now;
    end
    stamp_now = stamp_now + step;
    return stamp_now;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(delta_ticks, elapsed_ticks, frame_rate, paused);
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 150 == 0)
      stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 30);
      2:       out_stall <= ($urandom_range(0, 99) < 85);
      default: out_stall <= (stall_cycle[1:0] != 2'b00);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_UPDATE, 64'd1000);
    send_item(OP_UPDATE, 64'd1000);
    send_item(OP_UPDATE, 64'd17667);
    send_item(OP_UPDATE, 64'd17668);
    send_item(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_UPDATE, 64'h0000_0000_0000_0010);
    send_item(OP_PAUSE, 64'h20);
    send_item(OP_UPDATE, 64'h5000);
    send_item(OP_PAUSE, 64'h5100);
    send_item(OP_RESET, 64'h5200);
    send_item(OP_UPDATE, 64'h5300);
    send_item(OP_RESUME, 64'h8000);
    send_item(OP_UPDATE, 64'h8000 + 64'd16666);
    send_item(OP_RESUME, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_UPDATE, 64'h5555_5555_5555_5555);
    send_item(OP_RESET, 64'h0);
    send_item(OP_UPDATE, 64'd33333);

    pause_sender(1, 1'b1);
    write_reg(REG_RATE_GAIN, 32'hFFFF);
    write_reg(REG_AVG_EN, 32'd0);
    send_item(OP_UPDATE, 64'h0100_0000_0000_0000);
    send_item(OP_UPDATE, 64'h0100_0000_0001_0000);
    send_item(OP_UPDATE, 64'h0100_0000_0001_0000);
    stamp_now = 64'h0100_0000_0001_0000;

    for (int ph = 0; ph < PHASES; ph++) begin
      pause_sender(1, 1'b1);
      configure_phase(ph);
      burst_left = $urandom_range(0, 20);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(pick_op(), next_stamp());
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 49) == 0)
            pause_sender($urandom_range(1, 4), 1'b1);
          else
            pause_sender($urandom_range(1, 15), 1'b0);
        end else begin
          burst_left--;
        end
      end
    end

    pause_sender(1, 1'b1);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
